// File: sv/cartesian_admittance_axis_step_unit_defines.svh
// assertion macros for the admittance step unit checker
// no dependencies; included by the checker file
`ifndef CARTESIAN_ADMITTANCE_AXIS_STEP_UNIT_DEFINES_SVH
`define CARTESIAN_ADMITTANCE_AXIS_STEP_UNIT_DEFINES_SVH

// same-cycle implication, disabled while rst is high
`define CADM_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while rst is high
`define CADM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/cadm_pkg.sv
// shared types, constants and saturation helper for the admittance step unit
// no dependencies
package cadm_pkg;

   localparam int NUM_AXES   = 3;
   localparam int AXIS_W     = 2;
   localparam int AXIS_IDX_W = 2;
   localparam int DATA_W     = 32;
   localparam int TSTEP_W    = 16;
   localparam int FRAC_W     = 16;
   localparam int CSR_IDX_W  = 3;
   // wide enough for a shifted gain product and for any exact three-term sum
   localparam int SAT_W      = 49;

   localparam logic [AXIS_W-1:0] Z_AXIS = AXIS_W'(2);

   localparam logic FUNC_TICK = 1'b0;
   localparam logic FUNC_LOAD = 1'b1;

   localparam logic [DATA_W-1:0]  INV_MASS_RST  = 32'd6554;
   localparam logic [DATA_W-1:0]  DAMPING_RST   = 32'd16711680;
   localparam logic [DATA_W-1:0]  STIFFNESS_RST = 32'd32768000;
   localparam logic [TSTEP_W-1:0] TIME_STEP_RST = 16'd655;
   localparam logic [DATA_W-1:0]  Z_FLOOR_RST   = 32'd22938;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INV_MASS  = 3'd0,
      CSR_DAMPING   = 3'd1,
      CSR_STIFFNESS = 3'd2,
      CSR_TIME_STEP = 3'd3,
      CSR_Z_FLOOR   = 3'd4
   } cadm_csr_type;

   // one request to the shared gain multiplier
   typedef struct packed {
      logic [DATA_W-1:0]        gain;
      logic signed [DATA_W-1:0] operand;
   } cadm_mul_op_type;

   // clamp a wide signed value to signed 32 bits
   function automatic logic signed [DATA_W-1:0] cadm_sat(input logic signed [SAT_W-1:0] v);
      logic [SAT_W-DATA_W:0]    hi;
      logic signed [DATA_W-1:0] r;
      hi = v[SAT_W-1:DATA_W-1];
      if ((&hi) || (~|hi)) begin
         r = v[DATA_W-1:0];
      end else if (v[SAT_W-1]) begin
         r = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         r = {1'b0, {(DATA_W-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// File: sv/cadm_gain_mul.sv
// shared gain multiplier: unsigned gain times signed q16.16, floor, saturate
// depends on cadm_pkg; registers the product, then the saturated result, and takes a new operand pair every cycle
module cadm_gain_mul (
   input  logic                                 clock,
   input  cadm_pkg::cadm_mul_op_type            op,
   output logic signed [cadm_pkg::DATA_W-1:0]   result
);

   logic signed [2*cadm_pkg::DATA_W:0] product_ff;
   logic signed [cadm_pkg::DATA_W-1:0] result_ff;

   always_ff @(posedge clock) begin
      product_ff <= $signed({1'b0, op.gain}) * op.operand;
      // arithmetic drop of the fraction bits rounds toward minus infinity
      result_ff  <= cadm_pkg::cadm_sat(
         $signed(product_ff[2*cadm_pkg::DATA_W:cadm_pkg::FRAC_W]));
   end

   assign result = result_ff;

endmodule

// File: sv/cartesian_admittance_axis_step_unit.sv
// top level of the cartesian admittance axis step unit
// depends on cadm_pkg and cadm_gain_mul
//
// One transaction updates one axis of a translational mass-spring-damper
// admittance model held in q16.16 registers. A load transaction seeds the
// axis position with position_in and clears its velocity; a tick transaction
// computes acc = desired_acc + inv_mass*(damping*(desired_vel-vel)
// + stiffness*(position_in-pos) + force), the spring term being zero unless
// stiffness_on is set, then vel += acc*time_step and pos += vel*time_step,
// with z floored at z_floor. Every transaction gives one response with the
// axis and its new position and velocity; an axis out of range changes
// nothing and answers zeros. All five products go through one shared
// multiplier, which registers its product and then its saturated result,
// under a small sequencer; a load or an out-of-range axis skips the
// arithmetic. req_ready is high only while the sequencer is idle; a
// pending response does not block acceptance, but the next one waits for it.
// Configuration writes are taken on any cycle with csr_we and belong between
// transactions.
module cartesian_admittance_axis_step_unit (
   input  logic                                     clock,
   input  logic                                     reset,
   // configuration
   input  logic                                     csr_we,
   input  logic [cadm_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [cadm_pkg::DATA_W-1:0]              csr_wdata,
   // request channel
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_func,
   input  logic [cadm_pkg::AXIS_W-1:0]              req_axis,
   input  logic signed [cadm_pkg::DATA_W-1:0]       req_position_in,
   input  logic signed [cadm_pkg::DATA_W-1:0]       req_desired_vel,
   input  logic signed [cadm_pkg::DATA_W-1:0]       req_desired_acc,
   input  logic signed [cadm_pkg::DATA_W-1:0]       req_force_req,
   input  logic                                     req_stiffness_on,
   // response channel
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic [cadm_pkg::AXIS_W-1:0]              rsp_axis_out,
   output logic signed [cadm_pkg::DATA_W-1:0]       rsp_command_pos,
   output logic signed [cadm_pkg::DATA_W-1:0]       rsp_command_vel
);

   localparam int DW = cadm_pkg::DATA_W;
   localparam int SW = cadm_pkg::SAT_W;

   // sequencer: each issue state feeds the multiplier, whose result is taken
   // up by a later state (S_GET_D, S_GET_K, S_ACC, S_VEL, S_POS)
   typedef enum logic [3:0] {
      S_IDLE,
      S_DIFF,   // velocity and position errors
      S_ISS_D,  // issue damping * ev
      S_ISS_K,  // issue stiffness * ep
      S_GET_D,  // damping term + force
      S_GET_K,  // + spring term, saturate bracket
      S_ISS_M,  // issue inv_mass * bracket
      S_WT_M,
      S_ACC,    // acc = desired_acc + term
      S_ISS_V,  // issue time_step * acc
      S_WT_V,
      S_VEL,    // new velocity
      S_ISS_P,  // issue time_step * new velocity
      S_WT_P,
      S_POS,    // new position and z floor
      S_FIN     // write back and hand over the response
   } state_type;

   // configuration registers
   logic [DW-1:0]                        inv_mass_ff;
   logic [DW-1:0]                        damping_ff;
   logic [DW-1:0]                        stiffness_ff;
   logic [cadm_pkg::TSTEP_W-1:0]         time_step_ff;
   logic signed [DW-1:0]                 z_floor_ff;

   // per-axis state
   logic signed [DW-1:0] axis_position_ff [cadm_pkg::NUM_AXES];
   logic signed [DW-1:0] axis_velocity_ff [cadm_pkg::NUM_AXES];

   // latched request
   logic                                 func_ff;
   logic [cadm_pkg::AXIS_W-1:0]          axis_ff;
   logic signed [DW-1:0]                 position_in_ff;
   logic signed [DW-1:0]                 desired_vel_ff;
   logic signed [DW-1:0]                 desired_acc_ff;
   logic signed [DW-1:0]                 force_ff;
   logic                                 stiffness_on_ff;

   // datapath registers
   logic signed [DW-1:0]                 ev_ff;
   logic signed [DW-1:0]                 ep_ff;
   logic signed [SW-1:0]                 partial_ff;
   logic signed [DW-1:0]                 bracket_ff;
   logic signed [DW-1:0]                 acc_ff;
   logic signed [DW-1:0]                 vel_new_ff;
   logic signed [DW-1:0]                 pos_new_ff;

   // control and response registers
   state_type                            state_ff;
   state_type                            state_in;
   logic                                 rsp_valid_ff;
   logic [cadm_pkg::AXIS_W-1:0]          rsp_axis_ff;
   logic signed [DW-1:0]                 rsp_pos_ff;
   logic signed [DW-1:0]                 rsp_vel_ff;

   cadm_pkg::cadm_mul_op_type            mul_op;
   logic signed [DW-1:0]                 mul_res;

   logic [cadm_pkg::AXIS_IDX_W-1:0]      idx;
   logic                                 axis_ok;
   logic signed [DW-1:0]                 pos_cur;
   logic signed [DW-1:0]                 vel_cur;
   logic signed [DW-1:0]                 pos_sum;
   logic                                 req_fire;
   logic                                 fin_go;
   logic signed [DW-1:0]                 fin_pos;
   logic signed [DW-1:0]                 fin_vel;

   assign idx      = axis_ff[cadm_pkg::AXIS_IDX_W-1:0];
   assign axis_ok  = (axis_ff < cadm_pkg::AXIS_W'(cadm_pkg::NUM_AXES));
   assign pos_cur  = axis_position_ff[idx];
   assign vel_cur  = axis_velocity_ff[idx];
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire = req_valid && req_ready;
   // the response register must be free before the result is handed over
   assign fin_go   = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);

   cadm_gain_mul u_gain_mul (
      .clock  (clock),
      .op     (mul_op),
      .result (mul_res)
   );

   // multiplier operand select
   always_comb begin
      mul_op = '0;
      case (state_ff)
         S_ISS_D: begin
            mul_op.gain    = damping_ff;
            mul_op.operand = ev_ff;
         end
         S_ISS_K: begin
            mul_op.gain    = stiffness_ff;
            mul_op.operand = ep_ff;
         end
         S_ISS_M: begin
            mul_op.gain    = inv_mass_ff;
            mul_op.operand = bracket_ff;
         end
         S_ISS_V: begin
            mul_op.gain    = DW'(time_step_ff);
            mul_op.operand = acc_ff;
         end
         S_ISS_P: begin
            mul_op.gain    = DW'(time_step_ff);
            mul_op.operand = vel_new_ff;
         end
         default: begin
            mul_op = '0;
         end
      endcase
   end

   assign pos_sum = cadm_pkg::cadm_sat(SW'(pos_cur) + SW'(mul_res));

   // final values per transaction kind
   always_comb begin
      if (!axis_ok) begin
         fin_pos = '0;
         fin_vel = '0;
      end else if (func_ff == cadm_pkg::FUNC_LOAD) begin
         fin_pos = position_in_ff;
         fin_vel = '0;
      end else begin
         fin_pos = pos_new_ff;
         fin_vel = vel_new_ff;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // loads and out-of-range axes skip the arithmetic
               if ((req_func == cadm_pkg::FUNC_LOAD) ||
                   (req_axis >= cadm_pkg::AXIS_W'(cadm_pkg::NUM_AXES))) begin
                  state_in = S_FIN;
               end else begin
                  state_in = S_DIFF;
               end
            end
         end
         S_DIFF:  state_in = S_ISS_D;
         S_ISS_D: state_in = S_ISS_K;
         S_ISS_K: state_in = S_GET_D;
         S_GET_D: state_in = S_GET_K;
         S_GET_K: state_in = S_ISS_M;
         S_ISS_M: state_in = S_WT_M;
         S_WT_M:  state_in = S_ACC;
         S_ACC:   state_in = S_ISS_V;
         S_ISS_V: state_in = S_WT_V;
         S_WT_V:  state_in = S_VEL;
         S_VEL:   state_in = S_ISS_P;
         S_ISS_P: state_in = S_WT_P;
         S_WT_P:  state_in = S_POS;
         S_POS:   state_in = S_FIN;
         S_FIN: begin
            if (fin_go) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         inv_mass_ff  <= cadm_pkg::INV_MASS_RST;
         damping_ff   <= cadm_pkg::DAMPING_RST;
         stiffness_ff <= cadm_pkg::STIFFNESS_RST;
         time_step_ff <= cadm_pkg::TIME_STEP_RST;
         z_floor_ff   <= cadm_pkg::Z_FLOOR_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            cadm_pkg::CSR_INV_MASS:  inv_mass_ff  <= csr_wdata;
            cadm_pkg::CSR_DAMPING:   damping_ff   <= csr_wdata;
            cadm_pkg::CSR_STIFFNESS: stiffness_ff <= csr_wdata;
            cadm_pkg::CSR_TIME_STEP: time_step_ff <= csr_wdata[cadm_pkg::TSTEP_W-1:0];
            cadm_pkg::CSR_Z_FLOOR:   z_floor_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // axis state: cleared by reset, written once per transaction on an in-range axis
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cadm_pkg::NUM_AXES; i++) begin
            axis_position_ff[i] <= '0;
            axis_velocity_ff[i] <= '0;
         end
      end else if (fin_go && axis_ok) begin
         axis_position_ff[idx] <= fin_pos;
         axis_velocity_ff[idx] <= fin_vel;
      end
   end

   // request latch and datapath
   always_ff @(posedge clock) begin
      if (req_fire) begin
         func_ff         <= req_func;
         axis_ff         <= req_axis;
         position_in_ff  <= req_position_in;
         desired_vel_ff  <= req_desired_vel;
         desired_acc_ff  <= req_desired_acc;
         force_ff        <= req_force_req;
         stiffness_on_ff <= req_stiffness_on;
      end
      case (state_ff)
         S_DIFF: begin
            ev_ff <= cadm_pkg::cadm_sat(SW'(desired_vel_ff) - SW'(vel_cur));
            // spring term drops out when stiffness is off
            ep_ff <= stiffness_on_ff ?
                     cadm_pkg::cadm_sat(SW'(position_in_ff) - SW'(pos_cur)) : '0;
         end
         S_GET_D: partial_ff <= SW'(mul_res) + SW'(force_ff);
         S_GET_K: bracket_ff <= cadm_pkg::cadm_sat(partial_ff + SW'(mul_res));
         S_ACC:   acc_ff     <= cadm_pkg::cadm_sat(SW'(desired_acc_ff) + SW'(mul_res));
         S_VEL:   vel_new_ff <= cadm_pkg::cadm_sat(SW'(vel_cur) + SW'(mul_res));
         S_POS: begin
            if ((axis_ff == cadm_pkg::Z_AXIS) && (pos_sum < z_floor_ff)) begin
               pos_new_ff <= z_floor_ff;
            end else begin
               pos_new_ff <= pos_sum;
            end
         end
         default: ;
      endcase
   end

   // sequencer state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (fin_go) begin
            rsp_valid_ff <= 1'b1;
            rsp_axis_ff  <= axis_ff;
            rsp_pos_ff   <= fin_pos;
            rsp_vel_ff   <= fin_vel;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_axis_out    = rsp_axis_ff;
   assign rsp_command_pos = rsp_pos_ff;
   assign rsp_command_vel = rsp_vel_ff;

endmodule

// File: sv/cadm_checker.sv
// port-level checker for the admittance step unit, bound to the top level
// depends on cadm_pkg and cartesian_admittance_axis_step_unit_defines.svh
`include "cartesian_admittance_axis_step_unit_defines.svh"

module cadm_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  csr_we,
   input logic [cadm_pkg::CSR_IDX_W-1:0]        csr_index,
   input logic [cadm_pkg::DATA_W-1:0]           csr_wdata,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  req_func,
   input logic [cadm_pkg::AXIS_W-1:0]           req_axis,
   input logic signed [cadm_pkg::DATA_W-1:0]    req_position_in,
   input logic signed [cadm_pkg::DATA_W-1:0]    req_desired_vel,
   input logic signed [cadm_pkg::DATA_W-1:0]    req_desired_acc,
   input logic signed [cadm_pkg::DATA_W-1:0]    req_force_req,
   input logic                                  req_stiffness_on,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [cadm_pkg::AXIS_W-1:0]           rsp_axis_out,
   input logic signed [cadm_pkg::DATA_W-1:0]    rsp_command_pos,
   input logic signed [cadm_pkg::DATA_W-1:0]    rsp_command_vel
);

   // a stalled response keeps its payload
   `CADM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_axis_out) && $stable(rsp_command_pos) && $stable(rsp_command_vel), "response changed while stalled")

   // reset leaves the unit idle with no response pending
   `CADM_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, req_ready && !rsp_valid, "unit not idle after reset")

   // one transaction at a time: busy right after an acceptance
   `CADM_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request accepted while busy")

   // an out-of-range axis answers zeros
   `CADM_ASSERT_SAME(a_bad_axis_zero, clock, reset, rsp_valid && (rsp_axis_out == 2'd3), (rsp_command_pos == '0) && (rsp_command_vel == '0), "out-of-range axis changed values")

endmodule

bind cartesian_admittance_axis_step_unit cadm_checker u_cadm_checker (.*);
